FILE: design/bacq_pkg.sv
// Shared types and constants for the arm-button and combo qualifier.
`default_nettype none

package bacq_pkg;

  // Time base and qualification windows, in millisecond ticks.
  localparam int unsigned TIME_BITS      = 32;
  localparam int unsigned DEBOUNCE_TICKS = 20;
  localparam int unsigned LOCKOUT_TICKS  = 80;

  // Divider widths and their start values after reset.
  localparam int unsigned PERIOD_BITS  = 13;
  localparam int unsigned WINDOW_BITS  = 11;
  localparam int unsigned BEAT_START   = 1000;
  localparam int unsigned SAMPLE_START = 500;
  localparam int unsigned WINDOW_START = 300;

  // Mode and armed flags come out of reset at these values; the core keeps no
  // default registers, and writes to their indices are dropped.
  localparam logic DEFAULT_MODE_RST  = 1'b0;
  localparam logic DEFAULT_ARMED_RST = 1'b0;

  // Configuration port.
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 13;

  localparam logic [CFG_INDEX_BITS-1:0] REG_COMBO_WINDOW  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEFAULT_MODE  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEFAULT_ARMED = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BEAT_PERIOD   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_PERIOD = 3'd4;

  // Input operation codes.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_ARM   = 2'd1;
  localparam logic [1:0] OP_SW_B  = 2'd2;
  localparam logic [1:0] OP_SW_C  = 2'd3;

  // Event result codes.
  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_ARM_TOGGLED = 3'd1;
  localparam logic [2:0] EV_ARM_LOCKED  = 3'd2;
  localparam logic [2:0] EV_EDGE_OK     = 3'd3;
  localparam logic [2:0] EV_EDGE_BOUNCE = 3'd4;

  // Combo result codes.
  localparam logic [1:0] COMBO_NONE    = 2'd0;
  localparam logic [1:0] COMBO_FLIP    = 2'd1;
  localparam logic [1:0] COMBO_EXPIRED = 2'd2;

  typedef logic [TIME_BITS-1:0]   time_t;
  typedef logic [PERIOD_BITS-1:0] period_t;

  // Input word.
  typedef struct packed {
    logic [1:0] op;
    logic       level;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic       act_led;
    logic       armed_now;
    logic       mode_now;
    logic       b_pressed;
    logic       c_pressed;
    logic       heartbeat;
    logic       sample_strobe;
    logic [2:0] event_res;
    logic [1:0] combo;
  } out_word_t;

  // One configuration write as seen by the core.
  typedef struct packed {
    logic                      en;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
  } cfg_write_t;

endpackage

`default_nettype wire

FILE: design/bacq_core.sv
// Qualifier state and the single-pass step logic for one input word.
`default_nettype none

module bacq_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step_en,
  input  wire bacq_pkg::in_word_t  step_word,
  input  wire bacq_pkg::cfg_write_t cfg_wr,
  output bacq_pkg::out_word_t      step_res
);

  typedef enum logic [1:0] {
    WAIT_NONE = 2'd0,
    WAIT_C    = 2'd1,
    WAIT_B    = 2'd2
  } wait_t;

  // Configuration registers.
  logic [bacq_pkg::WINDOW_BITS-1:0] window_r;
  bacq_pkg::period_t                beat_period_r;
  bacq_pkg::period_t                sample_period_r;

  // Qualifier state.
  bacq_pkg::time_t   time_r, time_nxt;
  bacq_pkg::time_t   last_arm_r, last_arm_nxt;
  bacq_pkg::time_t   last_b_r, last_b_nxt;
  bacq_pkg::time_t   last_c_r, last_c_nxt;
  bacq_pkg::time_t   combo_start_r, combo_start_nxt;
  wait_t             wait_r, wait_nxt;
  logic              armed_r, armed_nxt;
  logic              mode_r, mode_nxt;
  logic              b_stable_r, b_stable_nxt;
  logic              c_stable_r, c_stable_nxt;
  bacq_pkg::period_t beat_r, beat_nxt;
  bacq_pkg::period_t sample_r, sample_nxt;
  logic              heart_r, heart_nxt;

  bacq_pkg::time_t arm_since;
  bacq_pkg::time_t sw_since;
  bacq_pkg::time_t combo_since;
  wait_t           wait_evt;
  logic            strobe;
  logic [2:0]      ev;
  logic [1:0]      combo;
  logic            sw_cond;

  // Configuration writes. The core keeps no default registers, so writes to
  // their indices are taken and dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r        <= bacq_pkg::WINDOW_BITS'(bacq_pkg::WINDOW_START);
      beat_period_r   <= bacq_pkg::PERIOD_BITS'(bacq_pkg::BEAT_START);
      sample_period_r <= bacq_pkg::PERIOD_BITS'(bacq_pkg::SAMPLE_START);
    end else if (cfg_wr.en) begin
      case (cfg_wr.index)
        bacq_pkg::REG_COMBO_WINDOW:  window_r <= cfg_wr.data[bacq_pkg::WINDOW_BITS-1:0];
        bacq_pkg::REG_BEAT_PERIOD:   beat_period_r <= cfg_wr.data;
        bacq_pkg::REG_SAMPLE_PERIOD: sample_period_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // Elapsed times for the arm lockout and the switch debounce.
  assign arm_since = time_r - last_arm_r;
  assign sw_since  = time_r - ((step_word.op == bacq_pkg::OP_SW_B) ? last_b_r : last_c_r);

  // Event handling: tick, arm press or switch edge.
  always_comb begin
    time_nxt        = time_r;
    last_arm_nxt    = last_arm_r;
    last_b_nxt      = last_b_r;
    last_c_nxt      = last_c_r;
    combo_start_nxt = combo_start_r;
    wait_evt        = wait_r;
    armed_nxt       = armed_r;
    b_stable_nxt    = b_stable_r;
    c_stable_nxt    = c_stable_r;
    beat_nxt        = beat_r;
    sample_nxt      = sample_r;
    heart_nxt       = heart_r;
    strobe          = 1'b0;
    ev              = bacq_pkg::EV_NONE;
    case (step_word.op)
      bacq_pkg::OP_TICK: begin
        time_nxt = time_r + bacq_pkg::time_t'(1);
        if (beat_r <= bacq_pkg::period_t'(1)) begin
          beat_nxt  = beat_period_r;
          heart_nxt = ~heart_r;
        end else begin
          beat_nxt = beat_r - bacq_pkg::period_t'(1);
        end
        if (sample_r <= bacq_pkg::period_t'(1)) begin
          sample_nxt = sample_period_r;
          strobe     = 1'b1;
        end else begin
          sample_nxt = sample_r - bacq_pkg::period_t'(1);
        end
      end
      bacq_pkg::OP_ARM: begin
        if (arm_since >= bacq_pkg::time_t'(bacq_pkg::LOCKOUT_TICKS)) begin
          last_arm_nxt = time_r;
          armed_nxt    = ~armed_r;
          ev           = bacq_pkg::EV_ARM_TOGGLED;
        end else begin
          ev = bacq_pkg::EV_ARM_LOCKED;
        end
      end
      default: begin
        if (sw_since >= bacq_pkg::time_t'(bacq_pkg::DEBOUNCE_TICKS)) begin
          if (step_word.op == bacq_pkg::OP_SW_B) begin
            last_b_nxt   = time_r;
            b_stable_nxt = step_word.level;
          end else begin
            last_c_nxt   = time_r;
            c_stable_nxt = step_word.level;
          end
          // A press, even at the same level, restarts the combo window.
          if (!step_word.level) begin
            combo_start_nxt = time_r;
            wait_evt = (step_word.op == bacq_pkg::OP_SW_B) ? WAIT_C : WAIT_B;
          end
          ev = bacq_pkg::EV_EDGE_OK;
        end else begin
          ev = bacq_pkg::EV_EDGE_BOUNCE;
        end
      end
    endcase
  end

  // Combo check on the updated state.
  assign combo_since = time_nxt - combo_start_nxt;

  always_comb begin
    wait_nxt = wait_evt;
    mode_nxt = mode_r;
    combo    = bacq_pkg::COMBO_NONE;
    if (wait_evt != WAIT_NONE) begin
      if (combo_since > bacq_pkg::time_t'(window_r)) begin
        wait_nxt = WAIT_NONE;
        combo    = bacq_pkg::COMBO_EXPIRED;
      end else if ((wait_evt == WAIT_C && !c_stable_nxt) ||
                   (wait_evt == WAIT_B && !b_stable_nxt)) begin
        wait_nxt = WAIT_NONE;
        mode_nxt = ~mode_r;
        combo    = bacq_pkg::COMBO_FLIP;
      end
    end
  end

  // Result word for this step.
  assign sw_cond = mode_nxt ? (!b_stable_nxt && !c_stable_nxt)
                            : (!b_stable_nxt || !c_stable_nxt);

  always_comb begin
    step_res.act_led       = sw_cond && armed_nxt;
    step_res.armed_now     = armed_nxt;
    step_res.mode_now      = mode_nxt;
    step_res.b_pressed     = !b_stable_nxt;
    step_res.c_pressed     = !c_stable_nxt;
    step_res.heartbeat     = heart_nxt;
    step_res.sample_strobe = strobe;
    step_res.event_res     = ev;
    step_res.combo         = combo;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r        <= '0;
      last_arm_r    <= '0;
      last_b_r      <= '0;
      last_c_r      <= '0;
      combo_start_r <= '0;
      wait_r        <= WAIT_NONE;
      armed_r       <= bacq_pkg::DEFAULT_ARMED_RST;
      mode_r        <= bacq_pkg::DEFAULT_MODE_RST;
      b_stable_r    <= 1'b1;
      c_stable_r    <= 1'b1;
      beat_r        <= bacq_pkg::PERIOD_BITS'(bacq_pkg::BEAT_START);
      sample_r      <= bacq_pkg::PERIOD_BITS'(bacq_pkg::SAMPLE_START);
      heart_r       <= 1'b0;
    end else if (step_en) begin
      time_r        <= time_nxt;
      last_arm_r    <= last_arm_nxt;
      last_b_r      <= last_b_nxt;
      last_c_r      <= last_c_nxt;
      combo_start_r <= combo_start_nxt;
      wait_r        <= wait_nxt;
      armed_r       <= armed_nxt;
      mode_r        <= mode_nxt;
      b_stable_r    <= b_stable_nxt;
      c_stable_r    <= c_stable_nxt;
      beat_r        <= beat_nxt;
      sample_r      <= sample_nxt;
      heart_r       <= heart_nxt;
    end
  end

  // A combo hit flips the stored mode.
  a_flip_mode: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && step_res.combo == bacq_pkg::COMBO_FLIP |=> mode_r != $past(mode_r))
    else $error("combo flip did not change mode");

  // An accepted arm press toggles the stored armed flag.
  a_arm_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && step_res.event_res == bacq_pkg::EV_ARM_TOGGLED |=> armed_r != $past(armed_r))
    else $error("arm toggle did not change armed flag");

  // Only a tick moves the time base.
  a_time_tick: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && step_word.op != bacq_pkg::OP_TICK |=> time_r == $past(time_r))
    else $error("time base moved on a non-tick word");

  // The sample strobe only fires on a tick.
  a_strobe_tick: assert property (@(posedge clk) disable iff (!rst_n)
    step_res.sample_strobe |-> step_word.op == bacq_pkg::OP_TICK)
    else $error("sample strobe on a non-tick word");

endmodule

`default_nettype wire

FILE: design/button_arm_combo_qualifier.sv
// Top level of the arm-button and two-switch combo qualifier.
// Each word (tick, arm press, switch B or C edge) enters an input register,
// is processed in one pass against the qualifier state, and leaves through a
// result register: one result word per input word. A new word can be taken
// every cycle while the output is not stalled; the core updates its state as
// each word moves from the input register to the result register.
// Configuration writes are always ready and should only be issued while no
// word is in flight.
`default_nettype none

module button_arm_combo_qualifier (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire bacq_pkg::in_word_t                     in_word,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output bacq_pkg::out_word_t                         out_word,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [bacq_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [bacq_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  logic                 s1_valid_r;
  bacq_pkg::in_word_t   s1_word_r;
  logic                 out_valid_r;
  bacq_pkg::out_word_t  out_word_r;
  logic                 out_free;
  logic                 s1_adv;
  bacq_pkg::out_word_t  step_res;
  bacq_pkg::cfg_write_t cfg_wr;

  // Handshake: the input register drains whenever the result register can load.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.en    = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_word_r <= in_word;
    end
  end

  bacq_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_adv),
    .step_word (s1_word_r),
    .cfg_wr    (cfg_wr),
    .step_res  (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_word_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Back-pressure only reaches the input when a word is waiting.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with nothing waiting");

  // The action LED never lights while disarmed.
  a_led_armed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.act_led |-> out_word_r.armed_now)
    else $error("action LED on while disarmed");

endmodule

`default_nettype wire
